/* design/qrv_pkg.sv */
`default_nettype none
package qrv_pkg;

  // defaults and fixed sizes
  localparam int ITER_STAGES_DEF = 28;
  localparam int ATAN_ENTRIES    = 40;
  localparam int ANG_W           = 44;   // signed angle, units 2^-40
  localparam int CRD_W           = 64;   // CORDIC datapath width
  localparam int SQRT_STEPS      = 32;   // one root bit per stage
  localparam int QUO_BITS        = 31;   // quotient bits of the scaling divide
  localparam int REM_W           = 36;   // square root remainder width

  localparam logic [63:0] SMALL_SCALE  = 64'd1000000000000000000;
  localparam logic [63:0] SMALL_V2_MAX = 64'd18;

  // per item side data carried down the pipe
  typedef struct packed {
    logic [2:0][31:0] amag;  // |c| << h for x, y, z
    logic [2:0]       neg;   // result sign per axis
    logic             tiny;
    logic             zero;
  } meta_t;

  // position of the highest set bit
  function automatic logic [5:0] msb_pos64(input logic [63:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/m) in units 2^-62, alternating series
  function automatic logic [63:0] atan_recip62(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] msq;
    p   = udiv64(64'h4000_0000_0000_0000, m);
    sum = '0;
    msq = m * m;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = udiv64(p, 64'(2 * k + 1));
        if ((k & 1) == 0) sum = sum + term;
        else sum = sum - term;
        p = udiv64(p, msq);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in units 2^-40, rounded
  function automatic logic [ANG_W-1:0] atan_entry(input int i);
    logic [63:0] s62;
    s62 = '0;
    if (i == 0) begin
      s62 = (atan_recip62(64'd5) << 2) - atan_recip62(64'd239);
    end else if (i <= 20) begin
      s62 = atan_recip62(64'd1 << i);
    end else if (i < ATAN_ENTRIES) begin
      return ANG_W'(64'd1 << (40 - i));
    end else begin
      return '0;
    end
    return ANG_W'((s62 + (64'd1 << 21)) >> 22);
  endfunction

endpackage
`default_nettype wire

/* design/qrv_if.sv */
`default_nettype none
// quaternion beat
interface qrv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// rotation vector beat
interface qrv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotvec_x;
  logic signed [31:0] rotvec_y;
  logic signed [31:0] rotvec_z;
  logic               small_angle;
  modport source (output valid, rotvec_x, rotvec_y, rotvec_z, small_angle, input ready);
  modport sink   (input valid, rotvec_x, rotvec_y, rotvec_z, small_angle, output ready);
endinterface
`default_nettype wire

/* design/qrv_front.sv */
`default_nettype none
module qrv_front import qrv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] quat_x,
  input  wire logic signed [31:0] quat_y,
  input  wire logic signed [31:0] quat_z,
  input  wire logic signed [31:0] quat_w,
  output logic                    out_valid,
  output meta_t                   out_meta,
  output logic [31:0]             out_root,
  output logic [62:0]             out_xs
);

  logic [3:0][31:0] q;
  assign q = {quat_w, quat_z, quat_y, quat_x};

  // stage 1: magnitudes and signs
  logic             v1_r;
  logic [3:0][31:0] mag1_r, mag1_nxt;
  logic [2:0]       neg1_r, neg1_nxt;
  logic             zero1_r;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mag1_nxt[j] = q[j][31] ? (~q[j] + 32'd1) : q[j];
    end
    for (int j = 0; j < 3; j++) begin
      neg1_nxt[j] = q[j][31] ^ q[3][31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      zero1_r <= (q == '0);
    end
  end

  // stage 2: squares
  logic             v2s_r;
  logic [3:0][63:0] sq2_r;
  logic [3:0][31:0] mag2_r;
  logic [2:0]       neg2_r;
  logic             zero2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2s_r <= 1'b0;
    end else if (en) begin
      v2s_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        sq2_r[j] <= mag1_r[j] * mag1_r[j];
      end
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
    end
  end

  // stage 3: vector norm squared
  logic             v3_r;
  logic [63:0]      v2_3_r, w2_3_r;
  logic [3:0][31:0] mag3_r;
  logic [2:0]       neg3_r;
  logic             zero3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      w2_3_r  <= sq2_r[3];
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
    end
  end

  // stage 4: small angle test and scale exponent
  logic             v4_r;
  logic [63:0]      v2_4_r;
  logic [4:0]       h4_r, h4_nxt;
  logic             small4_r, small4_nxt;
  logic [3:0][31:0] mag4_r;
  logic [2:0]       neg4_r;
  logic             zero4_r;
  logic [5:0]       lz4;

  always_comb begin
    lz4        = 6'd63 - msb_pos64(v2_3_r);
    h4_nxt     = lz4[5:1];
    small4_nxt = (v2_3_r <= SMALL_V2_MAX) &&
                 ((64'(v2_3_r[4:0]) * SMALL_SCALE) < (v2_3_r + w2_3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_4_r   <= v2_3_r;
      h4_r     <= h4_nxt;
      small4_r <= small4_nxt;
      mag4_r   <= mag3_r;
      neg4_r   <= neg3_r;
      zero4_r  <= zero3_r;
    end
  end

  // stage 5 and root pipe registers (index 0 is stage 5)
  logic              sq_v_r    [0:SQRT_STEPS];
  meta_t             sq_m_r    [0:SQRT_STEPS];
  logic [63:0]       sq_vs_r   [0:SQRT_STEPS];
  logic [62:0]       sq_xs_r   [0:SQRT_STEPS];
  logic [REM_W-1:0]  sq_rem_r  [0:SQRT_STEPS];
  logic [31:0]       sq_root_r [0:SQRT_STEPS];

  meta_t             m5_nxt;
  logic [62:0]       sh5 [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sh5[j]         = {31'd0, mag4_r[j]} << h4_r;
      m5_nxt.amag[j] = sh5[j][31:0];
    end
    m5_nxt.neg  = neg4_r;
    m5_nxt.tiny = small4_r;
    m5_nxt.zero = zero4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_m_r[0]    <= m5_nxt;
      sq_vs_r[0]   <= v2_4_r << {h4_r, 1'b0};
      sq_xs_r[0]   <= {31'd0, mag4_r[3]} << h4_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] t_w, trial_w, rem_nxt;
    logic [31:0]      root_nxt;

    always_comb begin
      t_w     = {sq_rem_r[k][REM_W-3:0], sq_vs_r[k][63-2*k -: 2]};
      trial_w = {2'b00, sq_root_r[k], 2'b01};
      if (t_w >= trial_w) begin
        rem_nxt  = t_w - trial_w;
        root_nxt = {sq_root_r[k][30:0], 1'b1};
      end else begin
        rem_nxt  = t_w;
        root_nxt = {sq_root_r[k][30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m_r[k+1]    <= sq_m_r[k];
        sq_vs_r[k+1]   <= sq_vs_r[k];
        sq_xs_r[k+1]   <= sq_xs_r[k];
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
      end
    end
  end

  assign out_valid = sq_v_r[SQRT_STEPS];
  assign out_meta  = sq_m_r[SQRT_STEPS];
  assign out_root  = sq_root_r[SQRT_STEPS];
  assign out_xs    = sq_xs_r[SQRT_STEPS];

endmodule
`default_nettype wire

/* design/qrv_cordic.sv */
`default_nettype none
module qrv_cordic import qrv_pkg::*; #(
  parameter int ITER_STAGES = ITER_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire meta_t       in_meta,
  input  wire logic [31:0] in_root,
  input  wire logic [62:0] in_xs,
  output logic             out_valid,
  output meta_t            out_meta,
  output logic [31:0]      out_root,
  output logic [31:0]      out_theta
);

  localparam int NSTG = (ITER_STAGES < ATAN_ENTRIES) ? ITER_STAGES : ATAN_ENTRIES;

  // stage A: leading one of the pair
  logic        va_r;
  logic [5:0]  pos_a_r;
  logic [62:0] xs_a_r;
  logic [31:0] root_a_r;
  meta_t       meta_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_a_r  <= msb_pos64({1'b0, in_xs | {31'd0, in_root}});
      xs_a_r   <= in_xs;
      root_a_r <= in_root;
      meta_a_r <= in_meta;
    end
  end

  // stage B: align so the larger lies in [2^59, 2^60)
  logic signed [CRD_W-1:0] c_x_r    [0:NSTG];
  logic signed [CRD_W-1:0] c_y_r    [0:NSTG];
  logic signed [ANG_W-1:0] c_a_r    [0:NSTG];
  logic                    c_v_r    [0:NSTG];
  meta_t                   c_m_r    [0:NSTG];
  logic [31:0]             c_root_r [0:NSTG];

  logic [CRD_W-1:0] xb_nxt, yb_nxt, xb_raw, yb_raw;

  always_comb begin
    xb_raw = {1'b0, xs_a_r};
    yb_raw = {32'd0, root_a_r};
    if (pos_a_r >= 6'd60) begin
      xb_nxt = xb_raw >> (pos_a_r - 6'd59);
      yb_nxt = yb_raw >> (pos_a_r - 6'd59);
    end else begin
      xb_nxt = xb_raw << (6'd59 - pos_a_r);
      yb_nxt = yb_raw << (6'd59 - pos_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r[0] <= 1'b0;
    end else if (en) begin
      c_v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r[0]    <= $signed(xb_nxt);
      c_y_r[0]    <= $signed(yb_nxt);
      c_a_r[0]    <= '0;
      c_m_r[0]    <= meta_a_r;
      c_root_r[0] <= root_a_r;
    end
  end

  // vectoring iterations, one per stage
  for (genvar i = 0; i < NSTG; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_entry(i);
    logic signed [CRD_W-1:0] dx, dy, x_nxt, y_nxt;
    logic signed [ANG_W-1:0] a_nxt;

    always_comb begin
      dx = c_y_r[i] >>> i;
      dy = c_x_r[i] >>> i;
      if (!c_y_r[i][CRD_W-1]) begin
        x_nxt = c_x_r[i] + dx;
        y_nxt = c_y_r[i] - dy;
        a_nxt = c_a_r[i] + ATAN_I;
      end else begin
        x_nxt = c_x_r[i] - dx;
        y_nxt = c_y_r[i] + dy;
        a_nxt = c_a_r[i] - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[i+1] <= 1'b0;
      end else if (en) begin
        c_v_r[i+1] <= c_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_x_r[i+1]    <= x_nxt;
        c_y_r[i+1]    <= y_nxt;
        c_a_r[i+1]    <= a_nxt;
        c_m_r[i+1]    <= c_m_r[i];
        c_root_r[i+1] <= c_root_r[i];
      end
    end
  end

  // clamp, double and round to units 2^-30
  logic             vt_r;
  logic [31:0]      theta_r;
  meta_t            meta_t_r;
  logic [31:0]      root_t_r;
  logic [ANG_W-1:0] ang_pos, ang_rnd;

  always_comb begin
    ang_pos = c_a_r[NSTG][ANG_W-1] ? '0 : c_a_r[NSTG];
    ang_rnd = ang_pos + ANG_W'(256);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (en) begin
      vt_r <= c_v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r  <= ang_rnd[40:9];
      meta_t_r <= c_m_r[NSTG];
      root_t_r <= c_root_r[NSTG];
    end
  end

  assign out_valid = vt_r;
  assign out_meta  = meta_t_r;
  assign out_root  = root_t_r;
  assign out_theta = theta_r;

endmodule
`default_nettype wire

/* design/qrv_scale.sv */
`default_nettype none
module qrv_scale import qrv_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire meta_t        in_meta,
  input  wire logic [31:0]  in_root,
  input  wire logic [31:0]  in_theta,
  output logic              out_valid,
  output logic [2:0][31:0]  out_rotvec,
  output logic              out_small
);

  // stage M: theta times scaled axis parts
  logic             vm_r;
  logic [2:0][63:0] prod_r;
  meta_t            meta_m_r;
  logic [31:0]      root_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= in_theta * in_meta.amag[j];
      end
      meta_m_r <= in_meta;
      root_m_r <= in_root;
    end
  end

  // divider pipe, index 0 holds the rounded numerator
  logic        dv_v_r    [0:QUO_BITS];
  meta_t       dv_m_r    [0:QUO_BITS];
  logic [31:0] dv_root_r [0:QUO_BITS];
  logic [33:0] dv_rem_r  [0:2][0:QUO_BITS];
  logic [30:0] dv_lo_r   [0:2][0:QUO_BITS];
  logic [30:0] dv_q_r    [0:2][0:QUO_BITS];

  logic [63:0] num_nxt [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_nxt[j] = prod_r[j] + {31'd0, root_m_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_m_r[0]    <= meta_m_r;
      dv_root_r[0] <= root_m_r;
      for (int j = 0; j < 3; j++) begin
        dv_rem_r[j][0] <= {1'b0, num_nxt[j][63:31]};
        dv_lo_r[j][0]  <= num_nxt[j][30:0];
        dv_q_r[j][0]   <= '0;
      end
    end
  end

  // restoring divide by 4*root, one quotient bit per stage
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    logic [34:0] dsr;
    logic [34:0] t_w [0:2];
    logic [33:0] rem_nxt [0:2];
    logic [30:0] q_nxt [0:2];

    always_comb begin
      dsr = {1'b0, dv_root_r[k], 2'b00};
      for (int j = 0; j < 3; j++) begin
        t_w[j] = {dv_rem_r[j][k], dv_lo_r[j][k][QUO_BITS-1-k]};
        if (t_w[j] >= dsr) begin
          rem_nxt[j] = 34'(t_w[j] - dsr);
          q_nxt[j]   = {dv_q_r[j][k][29:0], 1'b1};
        end else begin
          rem_nxt[j] = t_w[j][33:0];
          q_nxt[j]   = {dv_q_r[j][k][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_m_r[k+1]    <= dv_m_r[k];
        dv_root_r[k+1] <= dv_root_r[k];
        for (int j = 0; j < 3; j++) begin
          dv_rem_r[j][k+1] <= rem_nxt[j];
          dv_lo_r[j][k+1]  <= dv_lo_r[j][k];
          dv_q_r[j][k+1]   <= q_nxt[j];
        end
      end
    end
  end

  // output register: sign and special cases
  logic             vo_r;
  logic [2:0][31:0] rot_r, rot_nxt;
  logic             small_r;
  meta_t            mf;

  always_comb begin
    mf = dv_m_r[QUO_BITS];
    for (int j = 0; j < 3; j++) begin
      if (mf.zero || mf.tiny) begin
        rot_nxt[j] = '0;
      end else if (mf.neg[j]) begin
        rot_nxt[j] = ~{1'b0, dv_q_r[j][QUO_BITS]} + 32'd1;
      end else begin
        rot_nxt[j] = {1'b0, dv_q_r[j][QUO_BITS]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= dv_v_r[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r   <= rot_nxt;
      small_r <= mf.tiny & ~mf.zero;
    end
  end

  assign out_valid  = vo_r;
  assign out_rotvec = rot_r;
  assign out_small  = small_r;

endmodule
`default_nettype wire

/* design/quaternion_to_rotation_vector_top.sv */
// Throughput: one quaternion per cycle; the 32-stage root, the ITER_STAGES-stage
// CORDIC and the 31-stage divider are fully pipelined, the whole pipe holds on a stall.
// Reset: synchronous, active low rst_n clears every stage valid bit; no clearing pass.
`default_nettype none
module quaternion_to_rotation_vector_top import qrv_pkg::*; #(
  parameter int ITER_STAGES = ITER_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  qrv_in_if.sink   in_chan,
  qrv_out_if.source out_chan
);

  logic en;

  // front end to CORDIC
  logic        f_valid;
  meta_t       f_meta;
  logic [31:0] f_root;
  logic [62:0] f_xs;

  // CORDIC to scaling
  logic        c_valid;
  meta_t       c_meta;
  logic [31:0] c_root;
  logic [31:0] c_theta;

  logic             o_valid;
  logic [2:0][31:0] o_rot;
  logic             o_small;

  // whole pipe advances when the output beat is empty or taken
  assign en            = !o_valid || out_chan.ready;
  assign in_chan.ready = en;

  qrv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .quat_x    (in_chan.quat_x),
    .quat_y    (in_chan.quat_y),
    .quat_z    (in_chan.quat_z),
    .quat_w    (in_chan.quat_w),
    .out_valid (f_valid),
    .out_meta  (f_meta),
    .out_root  (f_root),
    .out_xs    (f_xs)
  );

  qrv_cordic #(.ITER_STAGES(ITER_STAGES)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_meta   (f_meta),
    .in_root   (f_root),
    .in_xs     (f_xs),
    .out_valid (c_valid),
    .out_meta  (c_meta),
    .out_root  (c_root),
    .out_theta (c_theta)
  );

  qrv_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (c_valid),
    .in_meta    (c_meta),
    .in_root    (c_root),
    .in_theta   (c_theta),
    .out_valid  (o_valid),
    .out_rotvec (o_rot),
    .out_small  (o_small)
  );

  assign out_chan.valid       = o_valid;
  assign out_chan.rotvec_x    = o_rot[0];
  assign out_chan.rotvec_y    = o_rot[1];
  assign out_chan.rotvec_z    = o_rot[2];
  assign out_chan.small_angle = o_small;

endmodule
`default_nettype wire

/* tb/sv/qrv_checker.sv */
`timescale 1ns / 1ps
// Watches both channels, predicts each rotation vector and compares in order.
module qrv_checker import qrv_pkg::*; #(
  parameter int ITER_STAGES = ITER_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  qrv_in_if    in_mon,
  qrv_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int EXP_DEPTH = 1024;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               tiny;
  } rotvec_t;

  // expected beats, written and read in order
  rotvec_t     exp_mem[EXP_DEPTH];
  int          wr_cnt;
  int          rd_cnt;
  logic [63:0] atan_lut[ATAN_ENTRIES];

  // atan(1/m) in units 2^-62 by the alternating series
  function automatic logic [63:0] arctan_inv(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] k;
    p   = 64'h4000_0000_0000_0000 / m;
    acc = '0;
    k   = '0;
    while (p != 0) begin
      if (k[0]) acc = acc - p / (2 * k + 1);
      else acc = acc + p / (2 * k + 1);
      p = p / (m * m);
      k++;
    end
    return acc;
  endfunction

  initial begin
    logic [63:0] s62;
    for (int i = 0; i < ATAN_ENTRIES; i++) begin
      if (i == 0) s62 = 4 * arctan_inv(64'd5) - arctan_inv(64'd239);
      else if (i <= 20) s62 = arctan_inv(64'd1 << i);
      if (i <= 20) atan_lut[i] = (s62 + (64'd1 << 21)) >> 22;
      else atan_lut[i] = 64'd1 << (40 - i);
    end
  end

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // axis-angle of one quaternion beat
  function automatic rotvec_t quat_to_rotvec(input logic signed [31:0] q[4]);
    rotvec_t     rv;
    logic [63:0] mag[4];
    logic [63:0] v2, w2, vs, root, xs, ys, theta, a, r;
    longint      cx, cy, dx, dy, ang;
    int          h, stages;
    rv = '0;
    for (int j = 0; j < 4; j++) mag[j] = q[j] < 0 ? 64'(-longint'(q[j])) : 64'(q[j]);
    if (q[0] == 0 && q[1] == 0 && q[2] == 0 && q[3] == 0) return rv;
    v2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    w2 = mag[3] * mag[3];
    // sine below threshold: vector forced to zero
    if (v2 <= 64'd18 && v2 * 64'd1000000000000000000 < v2 + w2) begin
      rv.tiny = 1'b1;
      return rv;
    end
    h  = 0;
    vs = v2;
    while (h < 31 && vs[63:62] == 2'b00) begin
      vs = vs << 2;
      h++;
    end
    root = root64(vs);
    xs   = mag[3] << h;
    ys   = root;
    while ((xs | ys) >= (64'd1 << 60)) begin
      xs = xs >> 1;
      ys = ys >> 1;
    end
    while ((xs | ys) < (64'd1 << 59)) begin
      xs = xs << 1;
      ys = ys << 1;
    end
    // CORDIC vectoring
    cx     = longint'(xs);
    cy     = longint'(ys);
    ang    = 0;
    stages = ITER_STAGES < ATAN_ENTRIES ? ITER_STAGES : ATAN_ENTRIES;
    for (int i = 0; i < stages; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        ang = ang + longint'(atan_lut[i]);
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        ang = ang - longint'(atan_lut[i]);
      end
    end
    if (ang < 0) ang = 0;
    theta = (64'(ang) + 64'd256) >> 9;
    for (int j = 0; j < 3; j++) begin
      a = mag[j] << h;
      r = (theta * a + 2 * root) / (4 * root);
      if ((q[j] < 0) != (q[3] < 0)) r = -r;
      if (j == 0) rv.x = r[31:0];
      else if (j == 1) rv.y = r[31:0];
      else rv.z = r[31:0];
    end
    return rv;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  initial begin
    fail_count = 0;
    wr_cnt     = 0;
    rd_cnt     = 0;
  end

  // quaternion beats in
  always @(posedge clk) begin
    logic signed [31:0] q[4];
    if (rst_n && in_mon.valid && in_mon.ready) begin
      q[0] = in_mon.quat_x;
      q[1] = in_mon.quat_y;
      q[2] = in_mon.quat_z;
      q[3] = in_mon.quat_w;
      exp_mem[wr_cnt % EXP_DEPTH] = quat_to_rotvec(q);
      wr_cnt++;
    end
  end

  // result beats out
  always @(posedge clk) begin
    rotvec_t want;
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (wr_cnt == rd_cnt) begin
        $display("%0t: unexpected result beat x=%0d y=%0d z=%0d small=%0b", $time,
                 out_mon.rotvec_x, out_mon.rotvec_y, out_mon.rotvec_z, out_mon.small_angle);
        fail_count++;
      end else begin
        want = exp_mem[rd_cnt % EXP_DEPTH];
        rd_cnt++;
        if (out_mon.rotvec_x !== want.x) begin
          $display("%0t: rotvec_x exp %0d got %0d", $time, want.x, out_mon.rotvec_x);
          fail_count++;
        end
        if (out_mon.rotvec_y !== want.y) begin
          $display("%0t: rotvec_y exp %0d got %0d", $time, want.y, out_mon.rotvec_y);
          fail_count++;
        end
        if (out_mon.rotvec_z !== want.z) begin
          $display("%0t: rotvec_z exp %0d got %0d", $time, want.z, out_mon.rotvec_z);
          fail_count++;
        end
        if (out_mon.small_angle !== want.tiny) begin
          $display("%0t: small_angle exp %0b got %0b", $time, want.tiny,
                   out_mon.small_angle);
          fail_count++;
        end
      end
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  localparam int ONE       = 1 << 29;   // 1.0 in Q2.29
  localparam int MAX_CYCLE = 400000;
  localparam int DRAIN     = 150;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycle;
  int   send_idle;
  int   recv_idle;
  int   hold_req;
  int   hold_cnt;

  qrv_in_if  in_chan ();
  qrv_out_if out_chan ();

  quaternion_to_rotation_vector_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  qrv_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // run limit
  initial cycle = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls plus requested long hold-offs
  initial begin
    out_chan.ready = 1'b0;
    hold_cnt       = 0;
  end
  always @(posedge clk) begin
    if (hold_req > 0 && hold_cnt == 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= $urandom_range(99) >= recv_idle;
    end
  end

  // one quaternion beat, with random gaps in front
  task automatic send_quat(input logic [31:0] x, y, z, w);
    while ($urandom_range(99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.quat_x <= x;
    in_chan.quat_y <= y;
    in_chan.quat_z <= z;
    in_chan.quat_w <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_part(input int kind);
    logic [31:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $urandom_range(2 * ONE) - ONE;
      2: v = $urandom_range(14) - 7;
      default: v = $signed($urandom) >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  initial begin
    int kind;
    in_chan.valid  = 1'b0;
    in_chan.quat_x = '0;
    in_chan.quat_y = '0;
    in_chan.quat_z = '0;
    in_chan.quat_w = '0;
    hold_req       = 0;
    send_idle      = 36;
    recv_idle      = 72;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, pure scalar, extremes, boundary of the small angle test
    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, ONE);
    send_quat(0, 0, 0, -ONE);
    send_quat(0, 0, 0, 32'h8000_0000);
    send_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_quat(32'h8000_0000, 0, 0, 0);
    send_quat(0, 32'h7fff_ffff, 0, 0);
    send_quat(0, 0, ONE, 0);
    send_quat(1, 0, 0, ONE);
    send_quat(4, 0, 0, 32'h7fff_ffff);
    send_quat(4, 1, 1, 1);
    send_quat(5, 0, 0, 32'h7fff_ffff);
    send_quat(-3, 3, 0, 32'h8000_0000);
    send_quat(1, 1, 1, 0);
    send_quat(ONE, 0, 0, -ONE);
    send_quat(-ONE, ONE, -ONE, ONE);
    send_quat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_quat(ONE / 2, -ONE / 2, ONE / 2, -ONE / 2);
    send_quat(1, 0, 0, 0);

    // random, three stall phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 36 : ph == 1 ? 72 : 0;
      recv_idle = ph == 0 ? 72 : ph == 1 ? 36 : 0;
      if (ph == 1) begin
        // sender pauses until the pipe has drained
        in_chan.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      if (ph == 2) hold_req = 400;
      for (int n = 0; n < 500; n++) begin
        kind = $urandom_range(4);
        if (kind == 4) send_quat(rand_part(2), rand_part(2), rand_part(2), rand_part(0));
        else send_quat(rand_part(kind), rand_part(kind), rand_part(kind), rand_part(kind));
      end
    end
    in_chan.valid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
